>>> hdl/tsf_pkg.sv
// ----------------------------------------------------------------------------
// tsf_pkg: shared definitions for the temperature smoothing filter
// Field widths, saturation limits, register indexes, filter mode codes and reset values.
// ----------------------------------------------------------------------------
package tsf_pkg;

   // payload widths
   localparam int SAMPLE_W    = 12;
   localparam int ERR_W       = 24;
   localparam int WEIGHT_W    = 16;
   localparam int MODE_W      = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 24;

   // saturation limits of a filtered value
   localparam int SAMPLE_MAX = 2047;
   localparam int SAMPLE_MIN = -2048;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_FILTER_MODE      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SMOOTHING_WEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_NOISE_LEVEL      = 2'd2;

   // filter modes (the unused code behaves as pass through)
   localparam logic [MODE_W-1:0] MODE_PASS   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_EXP    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_KALMAN = 2'd2;

   // register reset values
   localparam logic [MODE_W-1:0]   MODE_RESET   = MODE_EXP;
   localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd13107;
   localparam logic [ERR_W-1:0]    NOISE_RESET  = 24'd65536;

endpackage

>>> hdl/tsf_req_if.sv
// ----------------------------------------------------------------------------
// tsf_req_if: sample input channel
// Valid/ready channel carrying one raw temperature sample per transaction.
// ----------------------------------------------------------------------------
interface tsf_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [tsf_pkg::SAMPLE_W-1:0] temp_sample;

   modport source (output valid, output temp_sample, input ready);
   modport sink   (input valid, input temp_sample, output ready);
endinterface

>>> hdl/tsf_rsp_if.sv
// ----------------------------------------------------------------------------
// tsf_rsp_if: filtered result channel
// Valid/ready channel carrying the filtered value and the update flag.
// ----------------------------------------------------------------------------
interface tsf_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [tsf_pkg::SAMPLE_W-1:0] filtered_temp;
   logic                                 sample_taken;

   modport source (output valid, output filtered_temp, output sample_taken, input ready);
   modport sink   (input valid, input filtered_temp, input sample_taken, output ready);
endinterface

>>> hdl/tsf_csr_if.sv
// ----------------------------------------------------------------------------
// tsf_csr_if: configuration write channel
// Valid/ready channel carrying a register index and its write data.
// ----------------------------------------------------------------------------
interface tsf_csr_if;
   logic                                valid;
   logic                                ready;
   logic [tsf_pkg::CSR_INDEX_W-1:0]     index;
   logic [tsf_pkg::CSR_DATA_W-1:0]      data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hdl/temperature_smoothing_filter.sv
// ----------------------------------------------------------------------------
// temperature_smoothing_filter: pass-through, exponential or Kalman smoothing
// Microcoded sequencer driving one shared multiplier, an accumulator and a
// one-bit-per-cycle restoring divider for the Kalman gain.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one signed sample in 1/16 C per transaction; rsp returns one
//   result per sample: the filtered value and whether the sample updated it.
//   csr writes filter_mode (0), smoothing_weight (1) and noise_level (2);
//   writing noise_level reloads the error estimate with 1.0. csr is always
//   ready; write it only while no sample is in flight.
//   One sample is processed at a time; req.ready is high only while the
//   sequencer waits at its first step. After acceptance the sequencer tests
//   for a first sample, a held (non-positive) sample and the mode, then runs
//   pass through (first sample or pass mode), the hold step, exponential
//   smoothing or a Kalman update, the gain divider taking one quotient bit
//   per cycle, and its emit step loads the result register. req.ready rises
//   again in the cycle after the result is loaded, even while rsp is stalled;
//   if the receiver still holds the previous result, the sequencer waits at
//   its emit step.
//   Reset (synchronous, active high) restores the register defaults, clears
//   the held value and sets the error estimate to 1.0.
// ----------------------------------------------------------------------------
module temperature_smoothing_filter #(
   parameter int FRACTION_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   tsf_req_if.sink      req,
   tsf_rsp_if.source    rsp,
   tsf_csr_if.sink      csr
);

   localparam int SW      = tsf_pkg::SAMPLE_W;
   localparam int EW      = tsf_pkg::ERR_W;
   localparam int SPLIT_W = EW / 2;
   localparam int MULB_W  = SW + 1;
   localparam int G_W     = FRACTION_BITS + 1;
   localparam int MULA_W  = (G_W > tsf_pkg::WEIGHT_W) ? G_W : tsf_pkg::WEIGHT_W;
   localparam int PROD_W  = MULA_W + 1 + MULB_W;
   localparam int ACC_W   = FRACTION_BITS + EW + 2;
   localparam int SHR_W   = ACC_W - FRACTION_BITS;
   localparam int CNT_W   = $clog2(FRACTION_BITS + 1);
   localparam int PC_W    = 5;

   // 1.0 and 0.1 in the error format, held to the error width
   localparam logic [EW:0]   ONE_WIDE  = (EW + 1)'(1) << FRACTION_BITS;
   localparam logic [EW-1:0] ERR_ONE   = ONE_WIDE[EW-1:0];
   localparam int            TENTH_INT = ((2 ** FRACTION_BITS) + 5) / 10;
   localparam logic [EW-1:0] ERR_TENTH = EW'(TENTH_INT);

   // ---- microcode word ----
   typedef enum logic [4:0] {
      OP_NOP, OP_LATCH, OP_SET_S, OP_HOLD, OP_LDW, OP_MUL_DIFF, OP_ACC_PREV,
      OP_SAT, OP_TENTH_PASS, OP_DIV_INIT, OP_DIV_STEP, OP_LDG, OP_MUL_EHI,
      OP_ACC_LOAD, OP_MUL_ELO, OP_ACC_SHADD, OP_ERR_UPD, OP_EMIT
   } op_type;

   typedef enum logic [1:0] {
      HOLD_NONE, HOLD_NO_ACCEPT, HOLD_OUT_BUSY
   } hold_type;

   typedef enum logic [3:0] {
      COND_NEVER, COND_ALWAYS, COND_FIRST, COND_NONPOS, COND_MODE_EXP,
      COND_MODE_KAL, COND_ERR_ZERO, COND_DIV_MORE
   } cond_type;

   typedef struct packed {
      op_type           op;
      hold_type         hold;
      cond_type         cond;
      logic [PC_W-1:0]  target;
   } ctrl_word_type;

   // program labels
   localparam logic [PC_W-1:0] P_WAIT  = 5'd0;
   localparam logic [PC_W-1:0] P_PASS  = 5'd5;
   localparam logic [PC_W-1:0] P_HOLD  = 5'd6;
   localparam logic [PC_W-1:0] P_EXP   = 5'd7;
   localparam logic [PC_W-1:0] P_SAT   = 5'd10;
   localparam logic [PC_W-1:0] P_KAL   = 5'd11;
   localparam logic [PC_W-1:0] P_DIV   = 5'd13;
   localparam logic [PC_W-1:0] P_TENTH = 5'd22;
   localparam logic [PC_W-1:0] P_EMIT  = 5'd23;

   // control store
   function automatic ctrl_word_type rom(input logic [PC_W-1:0] pc);
      ctrl_word_type w;
      w = '{OP_NOP, HOLD_NONE, COND_ALWAYS, P_WAIT};
      unique case (pc)
         P_WAIT:  w = '{OP_LATCH,      HOLD_NO_ACCEPT, COND_NEVER,    P_WAIT};
         5'd1:    w = '{OP_NOP,        HOLD_NONE,      COND_FIRST,    P_PASS};
         5'd2:    w = '{OP_NOP,        HOLD_NONE,      COND_NONPOS,   P_HOLD};
         5'd3:    w = '{OP_NOP,        HOLD_NONE,      COND_MODE_EXP, P_EXP};
         5'd4:    w = '{OP_NOP,        HOLD_NONE,      COND_MODE_KAL, P_KAL};
         P_PASS:  w = '{OP_SET_S,      HOLD_NONE,      COND_ALWAYS,   P_EMIT};
         P_HOLD:  w = '{OP_HOLD,       HOLD_NONE,      COND_ALWAYS,   P_EMIT};
         P_EXP:   w = '{OP_LDW,        HOLD_NONE,      COND_NEVER,    P_WAIT};
         5'd8:    w = '{OP_MUL_DIFF,   HOLD_NONE,      COND_NEVER,    P_WAIT};
         5'd9:    w = '{OP_ACC_PREV,   HOLD_NONE,      COND_NEVER,    P_WAIT};
         P_SAT:   w = '{OP_SAT,        HOLD_NONE,      COND_ALWAYS,   P_EMIT};
         P_KAL:   w = '{OP_NOP,        HOLD_NONE,      COND_ERR_ZERO, P_TENTH};
         5'd12:   w = '{OP_DIV_INIT,   HOLD_NONE,      COND_NEVER,    P_WAIT};
         P_DIV:   w = '{OP_DIV_STEP,   HOLD_NONE,      COND_DIV_MORE, P_DIV};
         5'd14:   w = '{OP_LDG,        HOLD_NONE,      COND_NEVER,    P_WAIT};
         5'd15:   w = '{OP_MUL_EHI,    HOLD_NONE,      COND_NEVER,    P_WAIT};
         5'd16:   w = '{OP_ACC_LOAD,   HOLD_NONE,      COND_NEVER,    P_WAIT};
         5'd17:   w = '{OP_MUL_ELO,    HOLD_NONE,      COND_NEVER,    P_WAIT};
         5'd18:   w = '{OP_ACC_SHADD,  HOLD_NONE,      COND_NEVER,    P_WAIT};
         5'd19:   w = '{OP_ERR_UPD,    HOLD_NONE,      COND_NEVER,    P_WAIT};
         5'd20:   w = '{OP_MUL_DIFF,   HOLD_NONE,      COND_NEVER,    P_WAIT};
         5'd21:   w = '{OP_ACC_PREV,   HOLD_NONE,      COND_ALWAYS,   P_SAT};
         P_TENTH: w = '{OP_TENTH_PASS, HOLD_NONE,      COND_ALWAYS,   P_EMIT};
         P_EMIT:  w = '{OP_EMIT,       HOLD_OUT_BUSY,  COND_ALWAYS,   P_WAIT};
         default: w = '{OP_NOP,        HOLD_NONE,      COND_ALWAYS,   P_WAIT};
      endcase
      return w;
   endfunction

   // ---- registers ----
   logic [PC_W-1:0]                pc_ff;
   logic [tsf_pkg::MODE_W-1:0]     mode_ff;
   logic [tsf_pkg::WEIGHT_W-1:0]   weight_ff;
   logic [EW-1:0]                  noise_ff;
   logic [EW-1:0]                  err_ff;
   logic signed [SW-1:0]           smoothed_ff;
   logic                           has_ff;
   logic signed [SW-1:0]           sample_ff;
   logic signed [MULB_W-1:0]       diff_ff;
   logic                           taken_ff;
   logic [MULA_W-1:0]              mula_ff;
   logic signed [PROD_W-1:0]       prod_ff;
   logic signed [ACC_W-1:0]        acc_ff;
   logic [EW:0]                    div_ff;
   logic [EW:0]                    rem_ff;
   logic [G_W-1:0]                 quo_ff;
   logic [CNT_W-1:0]               cnt_ff;
   logic                           rsp_valid_ff;
   logic signed [SW-1:0]           out_temp_ff;
   logic                           out_taken_ff;

   // ---- sequencer decode ----
   ctrl_word_type            cw;
   logic                     accept;
   logic                     out_busy;
   logic                     held;
   logic                     exec;
   logic                     jump;
   logic [PC_W-1:0]          pc_in;

   assign cw       = rom(pc_ff);
   assign accept   = req.valid && req.ready;
   assign out_busy = rsp_valid_ff && !rsp.ready;

   always_comb begin
      unique case (cw.hold)
         HOLD_NO_ACCEPT: held = !accept;
         HOLD_OUT_BUSY:  held = out_busy;
         default:        held = 1'b0;
      endcase
   end

   assign exec = !held;

   always_comb begin
      unique case (cw.cond)
         COND_ALWAYS:   jump = 1'b1;
         COND_FIRST:    jump = !has_ff;
         COND_NONPOS:   jump = (sample_ff <= 0);
         COND_MODE_EXP: jump = (mode_ff == tsf_pkg::MODE_EXP);
         COND_MODE_KAL: jump = (mode_ff == tsf_pkg::MODE_KALMAN);
         COND_ERR_ZERO: jump = (err_ff == '0);
         COND_DIV_MORE: jump = (cnt_ff != CNT_W'(1));
         default:       jump = 1'b0;
      endcase
   end

   always_comb begin
      if (held) begin
         pc_in = pc_ff;
      end else if (jump) begin
         pc_in = cw.target;
      end else begin
         pc_in = pc_ff + PC_W'(1);
      end
   end

   // ---- datapath combinational terms ----
   logic signed [MULB_W-1:0]  mulb;
   logic signed [PROD_W-1:0]  prod_in;
   logic signed [SHR_W-1:0]   acc_shr;
   logic signed [SW-1:0]      sat_val;
   logic [EW+1:0]             rem_dbl;
   logic                      rem_ge;

   // multiplier B operand: sample difference or one half of the error
   always_comb begin
      unique case (cw.op)
         OP_MUL_EHI: mulb = $signed({1'b0, err_ff[EW-1:SPLIT_W]});
         OP_MUL_ELO: mulb = $signed({1'b0, err_ff[SPLIT_W-1:0]});
         default:    mulb = diff_ff;
      endcase
   end

   assign prod_in = $signed({1'b0, mula_ff}) * mulb;

   // floor shift and clamp to the sample range
   assign acc_shr = $signed(acc_ff[ACC_W-1:FRACTION_BITS]);

   always_comb begin
      if (acc_shr > tsf_pkg::SAMPLE_MAX) begin
         sat_val = SW'(tsf_pkg::SAMPLE_MAX);
      end else if (acc_shr < tsf_pkg::SAMPLE_MIN) begin
         sat_val = SW'(tsf_pkg::SAMPLE_MIN);
      end else begin
         sat_val = acc_shr[SW-1:0];
      end
   end

   // restoring divider step
   assign rem_dbl = {rem_ff, 1'b0};
   assign rem_ge  = (rem_dbl >= {1'b0, div_ff});

   // ---- sequencer, datapath and configuration registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= P_WAIT;
         mode_ff      <= tsf_pkg::MODE_RESET;
         weight_ff    <= tsf_pkg::WEIGHT_RESET;
         noise_ff     <= tsf_pkg::NOISE_RESET;
         err_ff       <= ERR_ONE;
         smoothed_ff  <= '0;
         has_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff <= pc_in;

         // output register loads at the emit step, frees on a completed transaction
         rsp_valid_ff <= (exec && cw.op == OP_EMIT) || (rsp_valid_ff && !rsp.ready);

         // configuration writes
         if (csr.valid && csr.ready) begin
            unique case (csr.index)
               tsf_pkg::REG_FILTER_MODE: begin
                  mode_ff <= csr.data[tsf_pkg::MODE_W-1:0];
               end
               tsf_pkg::REG_SMOOTHING_WEIGHT: begin
                  weight_ff <= csr.data[tsf_pkg::WEIGHT_W-1:0];
               end
               tsf_pkg::REG_NOISE_LEVEL: begin
                  noise_ff <= csr.data[EW-1:0];
                  err_ff   <= ERR_ONE;
               end
               default: begin
               end
            endcase
         end

         if (exec) begin
            unique case (cw.op)
               OP_LATCH: begin
                  sample_ff <= req.temp_sample;
                  diff_ff   <= MULB_W'(req.temp_sample) - MULB_W'(smoothed_ff);
               end
               OP_SET_S: begin
                  smoothed_ff <= sample_ff;
                  has_ff      <= 1'b1;
                  taken_ff    <= 1'b1;
               end
               OP_HOLD: begin
                  taken_ff <= 1'b0;
               end
               OP_LDW: begin
                  mula_ff <= MULA_W'(weight_ff);
               end
               OP_MUL_DIFF, OP_MUL_EHI, OP_MUL_ELO: begin
                  prod_ff <= prod_in;
               end
               OP_ACC_PREV: begin
                  acc_ff <= (ACC_W'(smoothed_ff) <<< FRACTION_BITS) + ACC_W'(prod_ff);
               end
               OP_SAT: begin
                  smoothed_ff <= sat_val;
                  taken_ff    <= 1'b1;
               end
               OP_TENTH_PASS: begin
                  err_ff      <= ERR_TENTH;
                  smoothed_ff <= sample_ff;
                  taken_ff    <= 1'b1;
               end
               OP_DIV_INIT: begin
                  // top quotient bit is set only when the divisor equals the error
                  div_ff <= {1'b0, err_ff} + {1'b0, noise_ff};
                  rem_ff <= (noise_ff == '0) ? '0 : {1'b0, err_ff};
                  quo_ff <= G_W'(noise_ff == '0);
                  cnt_ff <= CNT_W'(FRACTION_BITS);
               end
               OP_DIV_STEP: begin
                  rem_ff <= rem_ge ? (EW + 1)'(rem_dbl - {1'b0, div_ff})
                                   : rem_dbl[EW:0];
                  quo_ff <= {quo_ff[G_W-2:0], rem_ge};
                  cnt_ff <= cnt_ff - CNT_W'(1);
               end
               OP_LDG: begin
                  mula_ff <= MULA_W'(quo_ff);
               end
               OP_ACC_LOAD: begin
                  acc_ff <= ACC_W'(prod_ff);
               end
               OP_ACC_SHADD: begin
                  acc_ff <= (acc_ff <<< SPLIT_W) + ACC_W'(prod_ff);
               end
               OP_ERR_UPD: begin
                  err_ff <= err_ff - acc_ff[FRACTION_BITS +: EW];
               end
               OP_EMIT: begin
                  out_temp_ff  <= smoothed_ff;
                  out_taken_ff <= taken_ff;
               end
               default: begin
               end
            endcase
         end
      end
   end

   // ---- ports ----
   assign req.ready         = (pc_ff == P_WAIT);
   assign csr.ready         = 1'b1;
   assign rsp.valid         = rsp_valid_ff;
   assign rsp.filtered_temp = out_temp_ff;
   assign rsp.sample_taken  = out_taken_ff;

   // ---- assertions ----
   // an accepted sample always moves the sequencer off the wait step
   a_accept_leaves_wait : assert property (@(posedge clock) disable iff (reset)
      accept |=> (pc_ff != P_WAIT))
      else $error("sequencer stayed at wait after accepting a sample");

   // the divider remainder stays below the divisor while iterating
   a_rem_below_div : assert property (@(posedge clock) disable iff (reset)
      (pc_ff == P_DIV) |-> (rem_ff < div_ff))
      else $error("divider remainder not below divisor");

   // the error estimate never grows in a Kalman update
   a_err_shrinks : assert property (@(posedge clock) disable iff (reset)
      (exec && cw.op == OP_ERR_UPD && !(csr.valid && csr.ready))
      |=> (err_ff <= $past(err_ff)))
      else $error("error estimate grew in update");

endmodule
